// ===== rtl/core/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap run allocator: map geometry,
// sequencer states and the carry of the byte-wise run search.
// ----------------------------------------------------------------------------
package bra_pkg;

	// Map geometry.
	localparam int MAP_BYTES  = 32;
	localparam int MAP_BITS   = MAP_BYTES * 8;
	localparam int BYTE_IDX_W = $clog2(MAP_BYTES);
	localparam int CNT_W      = BYTE_IDX_W + 1;
	localparam int BIT_W      = $clog2(MAP_BITS);
	localparam int RUN_W      = BIT_W + 1;
	localparam int CFG_W      = 6;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_DONE
	} bra_state_t;

	// Run in progress, carried from one byte to the next.
	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic [BIT_W-1:0] start;
	} scan_carry_t;

	// Result of scanning one byte.
	typedef struct packed {
		logic        hit;
		scan_carry_t carry;
	} scan_res_t;

endpackage

// ===== rtl/core/bitmap_run_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit
// First-fit allocator over a 256-bit occupancy bitmap: finds the lowest run
// of free bits of the requested length, marks it used and reports its start.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload               | Handshake
//  --------+-----------+-----------------------+----------------------
//  in      | input     | run_length            | in_valid / in_ready
//  out     | output    | found, start_bit      | out_valid / out_ready
//  cfg     | input     | cfg_data (bytes used) | cfg_valid / cfg_ready
//
// A rejected request (zero length or longer than the managed map) goes
// straight to the result state. Otherwise the managed bytes, at most 32,
// are scanned in order until a run is found, and the bytes the run touches
// are then marked; the shared byte scanner handles one byte per cycle. Reset clears the
// whole map at once and sets bytes in use to 32. A new request is taken
// while the previous result waits on the output.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit
	import bra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [8:0]       run_length,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output logic [7:0]       start_bit,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	bra_state_t            state_q, state_d;
	logic [7:0]            map_q [MAP_BYTES];
	logic [CFG_W-1:0]      bytes_in_use_q;
	logic [CNT_W-1:0]      nbytes_d, nbytes_q;
	logic [CNT_W-1:0]      scan_idx_q;
	logic [BYTE_IDX_W-1:0] mark_idx_q;
	logic [RUN_W-1:0]      need_q;
	logic [BIT_W-1:0]      start_q;
	logic [BIT_W-1:0]      end_bit;
	logic                  hit_q;
	scan_carry_t           carry_q;
	scan_res_t             scan_res;
	logic [7:0]            mark_mask;
	logic                  reject;
	logic                  in_beat;
	logic                  scan_step;
	logic                  res_load;
	logic                  out_valid_q;
	logic                  res_found_q;
	logic [7:0]            res_start_q;

	// Managed byte count, saturated to the map size.
	always_comb begin
		if (bytes_in_use_q > CFG_W'(MAP_BYTES)) begin
			nbytes_d = CNT_W'(MAP_BYTES);
		end else begin
			nbytes_d = CNT_W'(bytes_in_use_q);
		end
	end

	// Requests of zero length or longer than the managed bits fail at once.
	assign reject = (run_length == '0) || (run_length > RUN_W'({nbytes_d, 3'b000}));

	// Shared byte scanner.
	bra_byte_scan u_scan (
		.byte_bits (map_q[scan_idx_q[BYTE_IDX_W-1:0]]),
		.byte_idx  (scan_idx_q[BYTE_IDX_W-1:0]),
		.need      (need_q),
		.carry_in  (carry_q),
		.res       (scan_res)
	);

	// Last bit of the found run, and the bits of the current byte inside it.
	assign end_bit = BIT_W'({1'b0, start_q} + need_q - RUN_W'(1));

	always_comb begin
		logic [BIT_W-1:0] addr;
		for (int j = 0; j < 8; j++) begin
			addr         = {mark_idx_q, 3'(j)};
			mark_mask[j] = (addr >= start_q) && (addr <= end_bit);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = reject ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_idx_q == nbytes_q) begin
					state_d = S_DONE;
				end else if (scan_res.hit) begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				if (mark_idx_q == end_bit[BIT_W-1:3]) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = 1'b0;
		scan_step = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready  = 1'b1;
			S_SCAN:  scan_step = (scan_idx_q != nbytes_q);
			S_MARK:  ;
			S_DONE:  res_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// State and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			bytes_in_use_q <= CFG_W'(MAP_BYTES);
			hit_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				bytes_in_use_q <= cfg_data;
			end
			if (in_beat) begin
				hit_q <= 1'b0;
			end else if (scan_step && scan_res.hit) begin
				hit_q <= 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search and result datapath.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			need_q     <= run_length;
			nbytes_q   <= nbytes_d;
			scan_idx_q <= '0;
			carry_q    <= '0;
		end
		if (scan_step) begin
			carry_q    <= scan_res.carry;
			scan_idx_q <= scan_idx_q + CNT_W'(1);
			if (scan_res.hit) begin
				start_q    <= scan_res.carry.start;
				mark_idx_q <= scan_res.carry.start[BIT_W-1:3];
			end
		end
		if (state_q == S_MARK) begin
			mark_idx_q <= mark_idx_q + BYTE_IDX_W'(1);
		end
		if (res_load) begin
			res_found_q <= hit_q;
			res_start_q <= hit_q ? start_q : 8'd0;
		end
	end

	// Occupancy map: cleared at reset, one byte marked per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_BYTES; i++) begin
				map_q[i] <= '0;
			end
		end else if (state_q == S_MARK) begin
			map_q[mark_idx_q] <= map_q[mark_idx_q] | mark_mask;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = res_found_q;
	assign start_bit = res_start_q;

	// A rejected request goes straight to the result state.
	a_reject_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && reject) |=> (state_q == S_DONE))
		else $error("rejected request did not go to the result state");

	// The scan never runs beyond the managed bytes.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_idx_q <= nbytes_q))
		else $error("scan index beyond managed bytes");

	// Marking stays within the bytes of the found run.
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (hit_q && (mark_idx_q <= end_bit[BIT_W-1:3])))
		else $error("marking beyond the found run");

	// A failed result carries a zero start index.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (start_bit == 8'd0))
		else $error("failed result with non-zero start bit");

endmodule

// ===== rtl/core/bra_byte_scan.sv =====
// ----------------------------------------------------------------------------
// bra_byte_scan
// Scans the eight bits of one bitmap byte for free bits, extending the run
// carried in from the previous byte, and flags the bit at which the run
// reaches the wanted length.
// ----------------------------------------------------------------------------
module bra_byte_scan
	import bra_pkg::*;
(
	input  logic [7:0]            byte_bits,
	input  logic [BYTE_IDX_W-1:0] byte_idx,
	input  logic [RUN_W-1:0]      need,
	input  scan_carry_t           carry_in,
	output scan_res_t             res
);

	// Walk the bits LSB first; a used bit breaks the run, and the search
	// stops at the first bit that completes it.
	always_comb begin
		scan_carry_t c;
		logic        h;
		c = carry_in;
		h = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if (!h) begin
				if (byte_bits[j]) begin
					c.run = '0;
				end else begin
					if (c.run == '0) begin
						c.start = {byte_idx, 3'(j)};
					end
					c.run = c.run + RUN_W'(1);
					if (c.run == need) begin
						h = 1'b1;
					end
				end
			end
		end
		res.hit   = h;
		res.carry = c;
	end

endmodule

// ===== tb/bitmap_run_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit_tb
// Self-checking bench for the first-fit bitmap run allocator. A shadow copy
// of the occupancy map predicts found and start_bit for every accepted
// request. Directed requests cover rejected and exact-fit lengths, byte
// skipping and register extremes. Random phases then widen the managed map
// step by step, under bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit_tb
	import bra_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       found;
		logic [7:0] start_bit;
	} alloc_result_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_ready;
	logic [8:0]       run_length = '0;
	logic             out_valid;
	logic             out_ready  = 1'b0;
	logic             found;
	logic [7:0]       start_bit;
	logic             cfg_valid  = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data   = '0;

	// Shadow of the block's state and register.
	logic [MAP_BITS-1:0] occupied      = '0;
	logic [CFG_W-1:0]    managed_bytes = 6'd32;

	logic [8:0]    pending_lengths[$];
	alloc_result_t expected_allocs[$];
	int            mismatches   = 0;
	int            results_seen = 0;

	// Managed byte counts of the random phases, growing so that each phase
	// brings fresh free bits beyond those already taken.
	int random_phases[10] = '{6, 8, 10, 13, 16, 19, 22, 25, 28, 32};

	bitmap_run_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.run_length(run_length),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.start_bit (start_bit),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// First fit over the shadow map: the lowest run of free bits of the
	// wanted length inside the managed bytes is marked used.
	function automatic alloc_result_t allocate_run(input logic [8:0] wanted);
		alloc_result_t res;
		int            managed_bits;
		int            run;
		int            first;
		int            b;
		int            i;
		res          = '0;
		run          = 0;
		first        = 0;
		managed_bits = ((managed_bytes > MAP_BYTES) ? MAP_BYTES : int'(managed_bytes)) * 8;
		if (wanted != 0 && wanted <= managed_bits) begin
			for (b = 0; b < managed_bits && !res.found; b++) begin
				if (occupied[b]) begin
					run = 0;
				end else begin
					if (run == 0)
						first = b;
					run++;
					if (run == wanted) begin
						for (i = first; i <= b; i++)
							occupied[i] = 1'b1;
						res.found     = 1'b1;
						res.start_bit = 8'(first);
					end
				end
			end
		end
		return res;
	endfunction

	// Register write, only issued while the block is idle.
	task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid     <= 1'b0;
		managed_bytes  = value;
	endtask

	// Waits until every queued request has been sent and answered. The
	// queues are looked at on the falling edge, once the clocked processes
	// of the rising edge have settled.
	task automatic drain_requests();
		@(negedge clk);
		while (pending_lengths.size() != 0 || in_valid || expected_allocs.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			run_length <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_allocs.push_back(allocate_run(run_length));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_lengths.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					in_valid   <= 1'b1;
					run_length <= pending_lengths.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Result monitor and receiver: a rotating stall pattern, reloaded whenever its age
	// counter wraps, plus one long hold-off while requests are still being offered.
	logic [15:0] stall_pattern = '1;
	int          pattern_age   = 0;
	int          hold_left     = 0;
	bit          hold_done     = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_alloc;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			// Compare each result beat with the oldest prediction.
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_allocs.size() == 0) begin
					$error("result beat with no request outstanding: found %0d start_bit %0d",
						found, start_bit);
					mismatches++;
				end else begin
					exp_alloc = expected_allocs.pop_front();
					if (found !== exp_alloc.found) begin
						$error("found: expected %0d, actual %0d", exp_alloc.found, found);
						mismatches++;
					end
					if (start_bit !== exp_alloc.start_bit) begin
						$error("start_bit: expected %0d, actual %0d",
							exp_alloc.start_bit, start_bit);
						mismatches++;
					end
				end
			end

			// Hold off once the input side is busy, so the block backs up.
			if (!hold_done && results_seen >= 100 && in_valid) begin
				hold_done = 1'b1;
				hold_left = 300;
			end else if (hold_left > 0) begin
				hold_left--;
			end

			pattern_age++;
			if (pattern_age == 64) begin
				pattern_age = 0;
				case ($urandom_range(0, 3))
					0: stall_pattern = '1;
					1: stall_pattern = 16'($urandom);
					2: stall_pattern = 16'($urandom) | 16'($urandom);
					default: stall_pattern = 16'($urandom) & 16'($urandom);
				endcase
			end else begin
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			end
			out_ready <= (hold_left == 0) && stall_pattern[0];
		end
	end

	// Stimulus.
	initial begin
		int         phase;
		int         n;
		int         roll;
		int         region_bits;
		logic [8:0] len;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting of the register, on an empty map.
		pending_lengths = '{9'd1, 9'd3};
		drain_requests();

		// One byte managed: exact fit of the rest of the byte, then no fit, too long, zero.
		write_bytes_in_use(6'd1);
		pending_lengths = '{9'd4, 9'd1, 9'd9, 9'd0};
		drain_requests();

		// No bytes managed: everything fails.
		write_bytes_in_use(6'd0);
		pending_lengths = '{9'd1, 9'd0};
		drain_requests();

		// Two bytes: the full first byte is skipped; a run one bit too long fails.
		write_bytes_in_use(6'd2);
		pending_lengths = '{9'd1, 9'd8, 9'd7};
		drain_requests();

		// Register above the map size saturates; over-long lengths are rejected.
		write_bytes_in_use(6'd63);
		pending_lengths = '{9'd511, 9'd257, 9'd256, 9'd300, 9'd16};
		drain_requests();

		// Random phases over a growing managed region.
		for (phase = 0; phase < 10; phase++) begin
			write_bytes_in_use(CFG_W'(random_phases[phase]));
			region_bits = random_phases[phase] * 8;
			for (n = 0; n < 80; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					len = '0;
				else if (roll < 16)
					len = 9'($urandom_range(257, 511));
				else if (roll < 22)
					len = 9'd256;
				else if (roll < 60)
					len = 9'($urandom_range(1, 3));
				else if (roll < 80)
					len = 9'($urandom_range(4, 16));
				else
					len = 9'($urandom_range(1, region_bits + 4));
				pending_lengths.push_back(len);
			end
			drain_requests();
		end

		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog.
	initial begin
		#1_200_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
